// ===== rtl/ssp_pkg.sv =====
// shared constants, types and helpers for the serial port controller
package ssp_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int DATA_W = 16;
  localparam int BUS_W = 32;
  localparam int OFS_W = 14;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam cnt_t CNT_FULL = CNT_W'(FIFO_DEPTH);

  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [OFS_W-1:0] OFS_CTRL0 = OFS_W'(0);
  localparam logic [OFS_W-1:0] OFS_CTRL1 = OFS_W'(1);
  localparam logic [OFS_W-1:0] OFS_STATUS = OFS_W'(2);
  localparam logic [OFS_W-1:0] OFS_DATA = OFS_W'(4);

  typedef struct packed {
    logic step;
    logic push;
    logic pop;
  } fifo_ctl_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic ptr_t ptr_add(ptr_t p, cnt_t c);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(p) + (CNT_W + 1)'(c);
    if (s >= (CNT_W + 1)'(FIFO_DEPTH)) begin
      s = s - (CNT_W + 1)'(FIFO_DEPTH);
    end
    return PTR_W'(s);
  endfunction

endpackage

// ===== rtl/ssp_if.sv =====
// request and result channel interfaces of the serial port controller
interface ssp_in_if;
  import ssp_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [OFS_W-1:0] word_offset;
  logic word_access;
  logic [BUS_W-1:0] write_data;
  logic [DATA_W-1:0] reply_data;

  modport source (
    output valid, mode, word_offset, word_access, write_data, reply_data,
    input ready
  );
  modport sink (
    input valid, mode, word_offset, word_access, write_data, reply_data,
    output ready
  );
endinterface

interface ssp_out_if;
  import ssp_pkg::*;
  logic valid;
  logic ready;
  logic [BUS_W-1:0] read_data;
  logic access_ok;
  logic [DATA_W-1:0] tx_word;
  logic tx_sent;
  logic [DATA_W-1:0] tx_head;
  logic [4:0] word_bits;
  logic irq_out;
  logic rx_dma_req;
  logic tx_dma_req;
  logic busy_res;

  modport source (
    output valid, read_data, access_ok, tx_word, tx_sent, tx_head, word_bits,
    output irq_out, rx_dma_req, tx_dma_req, busy_res,
    input ready
  );
  modport sink (
    input valid, read_data, access_ok, tx_word, tx_sent, tx_head, word_bits,
    input irq_out, rx_dma_req, tx_dma_req, busy_res,
    output ready
  );
endinterface

// ===== rtl/ssp_fifo.sv =====
// circular fifo in a synchronous memory with a registered head read
module ssp_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  ssp_pkg::fifo_ctl_t ctl,
  input  ssp_pkg::word_t     push_data,
  output ssp_pkg::cnt_t      count,
  output ssp_pkg::word_t     head_data
);
  import ssp_pkg::*;

  word_t mem [FIFO_DEPTH];
  ptr_t  head_r;
  ptr_t  head_nxt;
  ptr_t  tail;
  cnt_t  count_r;
  cnt_t  count_nxt;
  word_t q_r;

  always_comb begin
    tail = ptr_add(head_r, count_r);
    head_nxt = ctl.pop ? ptr_inc(head_r) : head_r;
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      count_r <= '0;
    end else if (ctl.step) begin
      head_r <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && ctl.push) begin
      mem[tail] <= push_data;
    end
  end

  // head after the step, forwarded when a push lands in an empty fifo
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      q_r <= (ctl.push && count_r == '0) ? push_data : mem[head_nxt];
    end
  end

  assign count = count_r;
  assign head_data = q_r;

endmodule

// ===== rtl/synchronous_serial_port_fifo.sv =====
// serial port controller top level: registers, status and result pipeline
// each result is registered in s1 and then in the output register; one transaction
// is taken per cycle unless the output stalls; each fifo memory is read once and
// written at most once per transaction, with its head entry held in a read register
// reset: synchronous, clears control, fifo pointers and pipeline valids; sets status
// and lines to idle values; fifo memories are not cleared; no clearing pass is needed
module synchronous_serial_port_fifo (
  input logic      clk,
  input logic      rst_n,
  ssp_in_if.sink   in_ch,
  ssp_out_if.source out_ch
);
  import ssp_pkg::*;

  localparam int ST_TXNF = 2;
  localparam int ST_RXNE = 3;
  localparam int ST_BUSY = 4;
  localparam int ST_TXSVC = 5;
  localparam int ST_RXSVC = 6;
  localparam int ST_OVR = 7;

  typedef struct packed {
    logic [BUS_W-1:0] read_data;
    logic             access_ok;
    word_t            tx_word;
    logic             tx_sent;
  } s1_t;

  typedef struct packed {
    logic [BUS_W-1:0] read_data;
    logic             access_ok;
    word_t            tx_word;
    logic             tx_sent;
    word_t            tx_head;
    logic [4:0]       word_bits;
    logic             irq_out;
    logic             rx_dma_req;
    logic             tx_dma_req;
    logic             busy_res;
  } res_t;

  logic [BUS_W-1:0] ctrl0_r, ctrl0_nxt;
  logic [BUS_W-1:0] ctrl1_r, ctrl1_nxt;
  logic [15:0]      status_r, status_nxt;
  logic             irq_r, irq_nxt;
  logic             rx_dma_r, rx_dma_nxt;
  logic             tx_dma_r, tx_dma_nxt;

  logic  s1_v_r;
  s1_t   s1_r;
  s1_t   s1_nxt;
  logic  out_v_r;
  res_t  out_r;
  logic  out_load;

  logic acc;
  logic is_rw;
  logic wr;
  logic ofs_hit;
  logic ok;
  logic is_data;
  logic tick;
  logic tx_push;
  logic tx_pop;
  logic rx_pop;
  logic rx_push;
  logic rx_full;
  cnt_t tx_cnt, tx_cnt_nxt;
  cnt_t rx_cnt, rx_cnt_nxt;
  word_t tx_head_q;
  word_t rx_head_q;
  word_t rx_back;
  logic [BUS_W-1:0] rdata;
  fifo_ctl_t tx_ctl;
  fifo_ctl_t rx_ctl;

  assign out_load = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || out_load;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    is_rw = (in_ch.mode == MODE_READ || in_ch.mode == MODE_WRITE) && in_ch.word_access;
    wr = (in_ch.mode == MODE_WRITE);
    ofs_hit = (in_ch.word_offset == OFS_CTRL0) || (in_ch.word_offset == OFS_CTRL1) ||
              (in_ch.word_offset == OFS_STATUS) || (in_ch.word_offset == OFS_DATA);
    ok = is_rw && ofs_hit;
    is_data = is_rw && (in_ch.word_offset == OFS_DATA);
    tick = (in_ch.mode == MODE_TICK);
    tx_push = is_data && wr && (tx_cnt != CNT_FULL);
    rx_pop = is_data && !wr && (rx_cnt != '0);
    tx_pop = tick && (tx_cnt != '0);
    rx_full = (rx_cnt == CNT_FULL);
    rx_push = tx_pop && !rx_full;
    rx_back = ctrl1_r[2] ? tx_head_q : in_ch.reply_data;
    tx_cnt_nxt = tx_push ? tx_cnt + 1'b1 : (tx_pop ? tx_cnt - 1'b1 : tx_cnt);
    rx_cnt_nxt = rx_push ? rx_cnt + 1'b1 : (rx_pop ? rx_cnt - 1'b1 : rx_cnt);
  end

  assign tx_ctl = '{step: acc, push: tx_push, pop: tx_pop};
  assign rx_ctl = '{step: acc, push: rx_push, pop: rx_pop};

  ssp_fifo u_tx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tx_ctl),
    .push_data (in_ch.write_data[DATA_W-1:0]),
    .count     (tx_cnt),
    .head_data (tx_head_q)
  );

  ssp_fifo u_rx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rx_ctl),
    .push_data (rx_back),
    .count     (rx_cnt),
    .head_data (rx_head_q)
  );

  always_comb begin
    rdata = '0;
    if (ok && !wr) begin
      unique case (in_ch.word_offset)
        OFS_CTRL0:  rdata = ctrl0_r;
        OFS_CTRL1:  rdata = ctrl1_r;
        OFS_STATUS: rdata = BUS_W'(status_r);
        OFS_DATA:   rdata = rx_pop ? BUS_W'(rx_head_q) : '0;
        default:    rdata = '0;
      endcase
    end
  end

  always_comb begin
    ctrl0_nxt = ctrl0_r;
    ctrl1_nxt = ctrl1_r;
    status_nxt = status_r;
    irq_nxt = irq_r;
    rx_dma_nxt = rx_dma_r;
    tx_dma_nxt = tx_dma_r;
    if (acc) begin
      if (ok && wr) begin
        unique case (in_ch.word_offset)
          OFS_CTRL0:  ctrl0_nxt = in_ch.write_data;
          OFS_CTRL1:  ctrl1_nxt = in_ch.write_data;
          OFS_STATUS: status_nxt[ST_OVR] = in_ch.write_data[ST_OVR];
          OFS_DATA:   status_nxt[ST_BUSY] = status_r[ST_BUSY] | tx_push;
          default:    status_nxt = status_r;
        endcase
      end
      if (tick && tx_cnt == '0) begin
        status_nxt[ST_BUSY] = 1'b0;
      end
      if (tx_pop && rx_full) begin
        status_nxt[ST_OVR] = 1'b1;
      end
      if (tx_push || tx_pop) begin
        status_nxt[ST_TXNF] = (tx_cnt_nxt != CNT_FULL);
        status_nxt[11:8] = 4'(tx_cnt_nxt);
        status_nxt[ST_TXSVC] = (16'(tx_cnt_nxt) <= 16'(ctrl1_r[9:6]));
        tx_dma_nxt = status_nxt[ST_TXSVC];
      end
      if (rx_push || rx_pop) begin
        status_nxt[ST_RXNE] = (rx_cnt_nxt != '0);
        status_nxt[15:12] = 4'(16'(rx_cnt_nxt) - 16'd1);
        status_nxt[ST_RXSVC] = (16'(rx_cnt_nxt) > 16'(ctrl1_r[13:10]));
        rx_dma_nxt = status_nxt[ST_RXSVC];
      end
      if (tx_push || tx_pop || rx_push || rx_pop) begin
        irq_nxt = (status_nxt[ST_RXSVC] && ctrl1_r[0]) ||
                  (status_nxt[ST_TXSVC] && ctrl1_r[1]);
      end
    end
  end

  always_comb begin
    s1_nxt.read_data = rdata;
    s1_nxt.access_ok = ok;
    s1_nxt.tx_word = tx_pop ? tx_head_q : '0;
    s1_nxt.tx_sent = tx_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl0_r <= '0;
      ctrl1_r <= '0;
      status_r <= 16'h0024;
      irq_r <= 1'b0;
      rx_dma_r <= 1'b0;
      tx_dma_r <= 1'b1;
      s1_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      ctrl0_r <= ctrl0_nxt;
      ctrl1_r <= ctrl1_nxt;
      status_r <= status_nxt;
      irq_r <= irq_nxt;
      rx_dma_r <= rx_dma_nxt;
      tx_dma_r <= tx_dma_nxt;
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (out_load) begin
        s1_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // state registers hold the post-transaction view of the item waiting in s1
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
    if (out_load) begin
      out_r.read_data <= s1_r.read_data;
      out_r.access_ok <= s1_r.access_ok;
      out_r.tx_word <= s1_r.tx_word;
      out_r.tx_sent <= s1_r.tx_sent;
      out_r.tx_head <= (tx_cnt != '0) ? tx_head_q : '0;
      out_r.word_bits <= 5'(ctrl0_r[3:0]) + 5'd1;
      out_r.irq_out <= irq_r;
      out_r.rx_dma_req <= rx_dma_r;
      out_r.tx_dma_req <= tx_dma_r;
      out_r.busy_res <= status_r[ST_BUSY];
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.read_data = out_r.read_data;
  assign out_ch.access_ok = out_r.access_ok;
  assign out_ch.tx_word = out_r.tx_word;
  assign out_ch.tx_sent = out_r.tx_sent;
  assign out_ch.tx_head = out_r.tx_head;
  assign out_ch.word_bits = out_r.word_bits;
  assign out_ch.irq_out = out_r.irq_out;
  assign out_ch.rx_dma_req = out_r.rx_dma_req;
  assign out_ch.tx_dma_req = out_r.tx_dma_req;
  assign out_ch.busy_res = out_r.busy_res;

`ifndef NO_ASSERTIONS
  a_txnf_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    status_r[ST_TXNF] == (tx_cnt != CNT_FULL))
    else $error("transmit not-full flag disagrees with fifo count");

  a_tx_level_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    status_r[11:8] == 4'(tx_cnt))
    else $error("transmit level field disagrees with fifo count");

  a_tick_pops_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && tx_pop) |=> (tx_cnt == $past(tx_cnt) - 1'b1))
    else $error("sending tick did not pop the transmit fifo");

  a_rx_overrun_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && tx_pop && rx_full) |=> (status_r[ST_OVR] && rx_cnt == CNT_FULL))
    else $error("tick into a full receive fifo did not flag overrun");
`endif

endmodule

// ===== tb/sv/synchronous_serial_port_fifo_tb.sv =====
// self-checking testbench for the serial port controller: bus accesses and ticks against a local model
module synchronous_serial_port_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [BUS_W-1:0] ST_TX_NOT_FULL = 32'h0000_0004;
  localparam logic [BUS_W-1:0] ST_RX_NOT_EMPTY = 32'h0000_0008;
  localparam logic [BUS_W-1:0] ST_BUSY = 32'h0000_0010;
  localparam logic [BUS_W-1:0] ST_TX_SERVICE = 32'h0000_0020;
  localparam logic [BUS_W-1:0] ST_RX_SERVICE = 32'h0000_0040;
  localparam logic [BUS_W-1:0] ST_OVERRUN = 32'h0000_0080;
  localparam logic [BUS_W-1:0] ST_RX_FIELDS = 32'h0000_f048;
  localparam logic [BUS_W-1:0] ST_TX_FIELDS = 32'h0000_0f24;

  localparam logic [BUS_W-1:0] CTRL1_RX_IRQ_EN = 32'h0000_0001;
  localparam logic [BUS_W-1:0] CTRL1_TX_IRQ_EN = 32'h0000_0002;
  localparam logic [BUS_W-1:0] CTRL1_LOOPBACK = 32'h0000_0004;

  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LENGTH = 150;
  localparam int RANDOM_PHASE_ITEMS = 207;

  typedef struct packed {
    logic [1:0] mode;
    logic [OFS_W-1:0] word_offset;
    logic word_access;
    logic [BUS_W-1:0] write_data;
    word_t reply_data;
  } ssp_item_t;

  typedef struct packed {
    logic [BUS_W-1:0] read_data;
    logic access_ok;
    word_t tx_word;
    logic tx_sent;
    word_t tx_head;
    logic [4:0] word_bits;
    logic irq_out;
    logic rx_dma_req;
    logic tx_dma_req;
    logic busy_res;
  } ssp_result_t;

  logic clk;
  logic rst_n;

  ssp_in_if in_ch();
  ssp_out_if out_ch();

  synchronous_serial_port_fifo u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  logic [BUS_W-1:0] ctrl0_m;
  logic [BUS_W-1:0] ctrl1_m;
  logic [BUS_W-1:0] status_m;
  word_t tx_words[$];
  word_t rx_words[$];
  logic irq_m;
  logic rx_dma_m;
  logic tx_dma_m;

  ssp_result_t pending_results[$];

  int send_idle_pct = 23;
  int recv_idle_pct = 63;
  logic stall_request = 1'b0;

  int fail_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int words_shifted = 0;
  int overruns_seen = 0;
  int dropped_pushes = 0;
  int empty_pops = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

  function automatic void refresh_irq();
    irq_m = (((status_m & ST_RX_SERVICE) != 0) && ((ctrl1_m & CTRL1_RX_IRQ_EN) != 0)) ||
            (((status_m & ST_TX_SERVICE) != 0) && ((ctrl1_m & CTRL1_TX_IRQ_EN) != 0));
  endfunction

  function automatic void refresh_rx();
    int cnt;
    cnt = rx_words.size();
    status_m &= ~ST_RX_FIELDS;
    if (cnt != 0) begin
      status_m |= ST_RX_NOT_EMPTY;
    end
    status_m[15:12] = 4'(cnt - 1);
    if (cnt > int'(ctrl1_m[13:10])) begin
      status_m |= ST_RX_SERVICE;
    end
    rx_dma_m = (status_m & ST_RX_SERVICE) != 0;
    refresh_irq();
  endfunction

  function automatic void refresh_tx();
    int cnt;
    cnt = tx_words.size();
    status_m &= ~ST_TX_FIELDS;
    if (cnt != FIFO_DEPTH) begin
      status_m |= ST_TX_NOT_FULL;
    end
    status_m[11:8] = 4'(cnt);
    if (cnt <= int'(ctrl1_m[9:6])) begin
      status_m |= ST_TX_SERVICE;
    end
    tx_dma_m = (status_m & ST_TX_SERVICE) != 0;
    refresh_irq();
  endfunction

  function automatic void reset_port_model();
    ctrl0_m = '0;
    ctrl1_m = '0;
    status_m = '0;
    tx_words.delete();
    rx_words.delete();
    irq_m = 1'b0;
    rx_dma_m = 1'b0;
    tx_dma_m = 1'b0;
    refresh_tx();
  endfunction

  // updates the port state for one transaction and returns the result it produces
  function automatic ssp_result_t apply_transaction(ssp_item_t it);
    ssp_result_t r;
    word_t v;
    r = '0;
    if ((it.mode == MODE_READ || it.mode == MODE_WRITE) && it.word_access) begin
      r.access_ok = 1'b1;
      case (it.word_offset)
        OFS_CTRL0: begin
          if (it.mode == MODE_WRITE) ctrl0_m = it.write_data;
          else r.read_data = ctrl0_m;
        end
        OFS_CTRL1: begin
          if (it.mode == MODE_WRITE) ctrl1_m = it.write_data;
          else r.read_data = ctrl1_m;
        end
        OFS_STATUS: begin
          if (it.mode == MODE_WRITE) begin
            status_m = (status_m & ~ST_OVERRUN) | (it.write_data & ST_OVERRUN);
          end else begin
            r.read_data = status_m;
          end
        end
        OFS_DATA: begin
          if (it.mode == MODE_WRITE) begin
            if (tx_words.size() < FIFO_DEPTH) begin
              status_m |= ST_BUSY;
              tx_words.push_back(it.write_data[DATA_W-1:0]);
              refresh_tx();
            end else begin
              dropped_pushes++;
            end
          end else if (rx_words.size() != 0) begin
            r.read_data = BUS_W'(rx_words.pop_front());
            refresh_rx();
          end else begin
            empty_pops++;
          end
        end
        default: r.access_ok = 1'b0;
      endcase
    end else if (it.mode == MODE_TICK) begin
      if (tx_words.size() == 0) begin
        status_m &= ~ST_BUSY;
      end else begin
        v = tx_words.pop_front();
        refresh_tx();
        r.tx_word = v;
        r.tx_sent = 1'b1;
        words_shifted++;
        if (rx_words.size() >= FIFO_DEPTH) begin
          status_m |= ST_OVERRUN;
          overruns_seen++;
        end else begin
          rx_words.push_back(((ctrl1_m & CTRL1_LOOPBACK) != 0) ? v : it.reply_data);
          refresh_rx();
        end
      end
    end
    r.tx_head = (tx_words.size() != 0) ? tx_words[0] : '0;
    r.word_bits = 5'd1 + 5'(ctrl0_m[3:0]);
    r.irq_out = irq_m;
    r.rx_dma_req = rx_dma_m;
    r.tx_dma_req = tx_dma_m;
    r.busy_res = (status_m & ST_BUSY) != 0;
    return r;
  endfunction

  function automatic ssp_item_t make_item(logic [1:0] mode, logic [OFS_W-1:0] ofs, logic wide,
                                          logic [BUS_W-1:0] wdata, word_t reply);
    ssp_item_t it;
    it.mode = mode;
    it.word_offset = ofs;
    it.word_access = wide;
    it.write_data = wdata;
    it.reply_data = reply;
    return it;
  endfunction

  // kind selects the flavor of a burst: pushes, ticks, pops, mixed, register access or noise
  function automatic ssp_item_t pick_item(int kind);
    ssp_item_t it;
    int sel;
    sel = $urandom_range(99);
    it = make_item(MODE_READ, OFS_DATA, 1'b1, $urandom(), word_t'($urandom()));
    if (kind < 30) begin
      it.mode = (sel < 85) ? MODE_WRITE : MODE_TICK;
    end else if (kind < 60) begin
      it.mode = (sel < 85) ? MODE_TICK : MODE_WRITE;
    end else if (kind < 78) begin
      it.mode = (sel < 85) ? MODE_READ : MODE_TICK;
    end else if (kind < 90) begin
      it.mode = (sel < 33) ? MODE_WRITE : (sel < 66) ? MODE_TICK : MODE_READ;
    end else if (kind < 96) begin
      it.mode = sel[0] ? MODE_WRITE : MODE_READ;
      case (sel % 3)
        0: it.word_offset = OFS_CTRL0;
        1: it.word_offset = OFS_CTRL1;
        default: it.word_offset = OFS_STATUS;
      endcase
    end else begin
      it.mode = 2'($urandom_range(3));
      it.word_access = 1'($urandom_range(1));
      if (sel < 50) it.word_offset = OFS_W'($urandom_range(16383));
      else it.word_offset = OFS_W'($urandom_range(7));
    end
    return it;
  endfunction

  task automatic send_item(input ssp_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= it.mode;
    in_ch.word_offset <= it.word_offset;
    in_ch.word_access <= it.word_access;
    in_ch.write_data <= it.write_data;
    in_ch.reply_data <= it.reply_data;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(apply_transaction(it));
    accepted_count++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic test_register_access();
    send_item(make_item(MODE_READ, OFS_CTRL0, 1'b1, '0, '0));
    send_item(make_item(MODE_READ, OFS_CTRL1, 1'b1, '0, '0));
    send_item(make_item(MODE_READ, OFS_STATUS, 1'b1, '0, '0));
    send_item(make_item(MODE_READ, OFS_DATA, 1'b1, '0, '0));
    send_item(make_item(MODE_WRITE, OFS_CTRL0, 1'b1, '1, '0));
    send_item(make_item(MODE_READ, OFS_CTRL0, 1'b1, '0, '0));
    send_item(make_item(MODE_WRITE, OFS_CTRL0, 1'b1, '0, '1));
    send_item(make_item(MODE_WRITE, OFS_CTRL1, 1'b1, '1, '0));
    send_item(make_item(MODE_READ, OFS_CTRL1, 1'b1, '0, '0));
    send_item(make_item(MODE_WRITE, OFS_STATUS, 1'b1, '1, '0));
    send_item(make_item(MODE_READ, OFS_STATUS, 1'b1, '0, '0));
    send_item(make_item(MODE_WRITE, OFS_STATUS, 1'b1, '0, '0));
    send_item(make_item(MODE_WRITE, OFS_CTRL0, 1'b0, '1, '0));
    send_item(make_item(MODE_READ, OFS_CTRL1, 1'b0, '0, '0));
    send_item(make_item(MODE_READ, OFS_W'(3), 1'b1, '0, '0));
    send_item(make_item(MODE_WRITE, '1, 1'b1, '1, '1));
    send_item(make_item(MODE_UNUSED, OFS_DATA, 1'b1, '1, '1));
    send_item(make_item(MODE_TICK, OFS_CTRL0, 1'b1, '0, '1));
    send_item(make_item(MODE_WRITE, OFS_DATA, 1'b1, '1, '0));
    send_item(make_item(MODE_WRITE, OFS_DATA, 1'b1, '0, '0));
    send_item(make_item(MODE_TICK, OFS_CTRL0, 1'b0, '0, '0));
    send_item(make_item(MODE_WRITE, OFS_CTRL1, 1'b1, '0, '0));
    send_item(make_item(MODE_TICK, OFS_CTRL0, 1'b0, '0, 16'ha5a5));
    send_item(make_item(MODE_READ, OFS_DATA, 1'b1, '0, '0));
    send_item(make_item(MODE_READ, OFS_DATA, 1'b1, '0, '0));
    send_item(make_item(MODE_TICK, OFS_CTRL0, 1'b0, '0, '1));
  endtask

  task automatic test_fifo_limits();
    send_item(make_item(MODE_WRITE, OFS_CTRL1, 1'b1, $urandom() | CTRL1_LOOPBACK, '0));
    repeat (FIFO_DEPTH + 1) send_item(make_item(MODE_WRITE, OFS_DATA, 1'b1, $urandom(), '0));
    repeat (FIFO_DEPTH + 1) send_item(make_item(MODE_TICK, OFS_DATA, 1'b1, '0, word_t'($urandom())));
    repeat (FIFO_DEPTH + 1) send_item(make_item(MODE_WRITE, OFS_DATA, 1'b1, $urandom(), '0));
    repeat (2) send_item(make_item(MODE_TICK, OFS_DATA, 1'b1, '0, word_t'($urandom())));
    repeat (FIFO_DEPTH + 1) send_item(make_item(MODE_READ, OFS_DATA, 1'b1, '0, '0));
    send_item(make_item(MODE_WRITE, OFS_STATUS, 1'b1, '0, '0));
    repeat (FIFO_DEPTH) send_item(make_item(MODE_TICK, OFS_DATA, 1'b1, '0, word_t'($urandom())));
    send_item(make_item(MODE_WRITE, OFS_CTRL1, 1'b1, '0, '0));
    repeat (FIFO_DEPTH + 1) send_item(make_item(MODE_READ, OFS_DATA, 1'b1, '0, '0));
  endtask

  task automatic run_random_traffic(input int n_items);
    int done;
    int kind;
    int burst;
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(99);
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && done < n_items; k++) begin
        send_item(pick_item(kind));
        done++;
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    go_quiet();
    @(posedge clk);
    stall_request = 1'b1;
    run_random_traffic(48);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 23;
    recv_idle_pct = 63;
    run_random_traffic(RANDOM_PHASE_ITEMS);
    send_idle_pct = 63;
    recv_idle_pct = 23;
    run_random_traffic(RANDOM_PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(RANDOM_PHASE_ITEMS);
  endtask

  // receiver: random holds, plus one long counted stall on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        hold_left = STALL_LENGTH;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void compare_field(string name, logic [BUS_W-1:0] want,
                                        logic [BUS_W-1:0] got);
    if (got !== want) begin
      $error("result %0d %s: expected 0x%0h, actual 0x%0h", checked_count, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    ssp_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transaction arrived with none outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("read_data", want.read_data, out_ch.read_data);
        compare_field("access_ok", want.access_ok, out_ch.access_ok);
        compare_field("tx_word", want.tx_word, out_ch.tx_word);
        compare_field("tx_sent", want.tx_sent, out_ch.tx_sent);
        compare_field("tx_head", want.tx_head, out_ch.tx_head);
        compare_field("word_bits", want.word_bits, out_ch.word_bits);
        compare_field("irq_out", want.irq_out, out_ch.irq_out);
        compare_field("rx_dma_req", want.rx_dma_req, out_ch.rx_dma_req);
        compare_field("tx_dma_req", want.tx_dma_req, out_ch.tx_dma_req);
        compare_field("busy_res", want.busy_res, out_ch.busy_res);
        checked_count++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_READ;
    in_ch.word_offset = OFS_CTRL0;
    in_ch.word_access = 1'b0;
    in_ch.write_data = '0;
    in_ch.reply_data = '0;
    reset_port_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_fifo_limits();
    test_backpressure();
    test_random_traffic();

    go_quiet();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d transactions and %0d checked results; %0d words shifted out",
             accepted_count, checked_count, words_shifted);
    $display("corner hits: %0d receive overruns, %0d dropped pushes, %0d reads of an empty fifo",
             overruns_seen, dropped_pushes, empty_pops);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ssp_pkg.sv
rtl/ssp_if.sv
rtl/ssp_fifo.sv
rtl/synchronous_serial_port_fifo.sv
tb/sv/synchronous_serial_port_fifo_tb.sv
